// File: rtl/dhg_pkg.sv
// Package for the diff hunk grouper: line-counter width, edit codes,
// hunk header type and the saturating increment.
// No dependencies.
package dhg_pkg;

	localparam int LINE_BITS = 20;
	localparam int CTX_BITS  = 8;

	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [CTX_BITS-1:0]  CTX_RESET = CTX_BITS'(3);

	// action codes
	localparam logic ACT_EDIT = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// edit kinds
	localparam logic [1:0] OP_EQUAL  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	typedef logic [LINE_BITS-1:0] line_t;
	typedef logic [CTX_BITS-1:0]  ctx_t;

	typedef struct packed {
		line_t old_start;
		line_t old_count;
		line_t new_start;
		line_t new_count;
	} hunk_hdr_t;

	// add one, holding at the line limit
	function automatic line_t sat_inc(input line_t v);
		return (v == LINE_MAX) ? v : v + line_t'(1);
	endfunction

endpackage

// File: rtl/dhg_in_if.sv
// Input channel of the diff hunk grouper: one edit operation or end of script.
// No dependencies.
interface dhg_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [1:0] op_kind;

	modport source (output valid, output action, output op_kind, input ready);
	modport sink   (input valid, input action, input op_kind, output ready);
endinterface

// File: rtl/dhg_out_if.sv
// Output channel of the diff hunk grouper: one hunk header per transaction.
// Depends on dhg_pkg.
interface dhg_out_if;
	logic                  valid;
	logic                  ready;
	dhg_pkg::line_t        old_start;
	dhg_pkg::line_t        old_count;
	dhg_pkg::line_t        new_start;
	dhg_pkg::line_t        new_count;

	modport source (output valid, output old_start, output old_count,
		output new_start, output new_count, input ready);
	modport sink   (input valid, input old_start, input old_count,
		input new_start, input new_count, output ready);
endinterface

// File: rtl/dhg_cfg_if.sv
// Configuration write channel of the diff hunk grouper (context line count).
// Depends on dhg_pkg.
interface dhg_cfg_if;
	logic          valid;
	logic          ready;
	dhg_pkg::ctx_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/dhg_core.sv
// Hunk tracking state: line positions, open hunk, trailing context and header.
// One edit transaction is applied per step. Depends on dhg_pkg.
module dhg_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               action,
	input  logic [1:0]         op_kind,
	input  dhg_pkg::ctx_t      context_lines,
	output logic               emit,
	output dhg_pkg::hunk_hdr_t hdr
);
	import dhg_pkg::*;

	logic  hunk_open_q, hunk_open_d;
	line_t old_position_q, old_position_d;
	line_t new_position_q, new_position_d;
	ctx_t  context_left_q, context_left_d;
	line_t hunk_old_start_q, hunk_old_start_d;
	line_t hunk_new_start_q, hunk_new_start_d;
	line_t hunk_old_count_q, hunk_old_count_d;
	line_t hunk_new_count_q, hunk_new_count_d;

	// leading context when a change opens a hunk
	line_t ctx_ext;
	line_t lead;
	line_t base_old_count, base_new_count;

	assign ctx_ext = line_t'(context_lines);
	assign lead    = (ctx_ext < old_position_q) ? ctx_ext : old_position_q;
	assign base_old_count = hunk_open_q ? hunk_old_count_q : lead;
	assign base_new_count = hunk_open_q ? hunk_new_count_q : lead;

	// header of the hunk being closed
	assign hdr = '{old_start: hunk_old_start_q, old_count: hunk_old_count_q,
		new_start: hunk_new_start_q, new_count: hunk_new_count_q};

	// next state
	always_comb begin
		hunk_open_d      = hunk_open_q;
		old_position_d   = old_position_q;
		new_position_d   = new_position_q;
		context_left_d   = context_left_q;
		hunk_old_start_d = hunk_old_start_q;
		hunk_new_start_d = hunk_new_start_q;
		hunk_old_count_d = hunk_old_count_q;
		hunk_new_count_d = hunk_new_count_q;
		emit             = 1'b0;
		if (action == ACT_END) begin
			emit             = hunk_open_q;
			hunk_open_d      = 1'b0;
			old_position_d   = '0;
			new_position_d   = '0;
			context_left_d   = '0;
			hunk_old_start_d = '0;
			hunk_new_start_d = '0;
			hunk_old_count_d = '0;
			hunk_new_count_d = '0;
		end else begin
			case (op_kind)
				OP_EQUAL: begin
					if (hunk_open_q) begin
						if (context_left_q != '0) begin
							hunk_old_count_d = sat_inc(hunk_old_count_q);
							hunk_new_count_d = sat_inc(hunk_new_count_q);
							context_left_d   = context_left_q - ctx_t'(1);
						end else begin
							emit             = 1'b1;
							hunk_open_d      = 1'b0;
							hunk_old_start_d = '0;
							hunk_new_start_d = '0;
							hunk_old_count_d = '0;
							hunk_new_count_d = '0;
						end
					end
					old_position_d = sat_inc(old_position_q);
					new_position_d = sat_inc(new_position_q);
				end
				OP_INSERT, OP_DELETE: begin
					context_left_d = context_lines;
					hunk_open_d    = 1'b1;
					if (!hunk_open_q) begin
						hunk_old_start_d = old_position_q - lead;
						hunk_new_start_d = (lead > new_position_q) ? '0
							: new_position_q - lead;
					end
					if (op_kind == OP_INSERT) begin
						hunk_new_count_d = sat_inc(base_new_count);
						hunk_old_count_d = base_old_count;
						new_position_d   = sat_inc(new_position_q);
					end else begin
						hunk_old_count_d = sat_inc(base_old_count);
						hunk_new_count_d = base_new_count;
						old_position_d   = sat_inc(old_position_q);
					end
				end
				default: begin
					// unused kind: no effect
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunk_open_q      <= 1'b0;
			old_position_q   <= '0;
			new_position_q   <= '0;
			context_left_q   <= '0;
			hunk_old_start_q <= '0;
			hunk_new_start_q <= '0;
			hunk_old_count_q <= '0;
			hunk_new_count_q <= '0;
		end else if (step) begin
			hunk_open_q      <= hunk_open_d;
			old_position_q   <= old_position_d;
			new_position_q   <= new_position_d;
			context_left_q   <= context_left_d;
			hunk_old_start_q <= hunk_old_start_d;
			hunk_new_start_q <= hunk_new_start_d;
			hunk_old_count_q <= hunk_old_count_d;
			hunk_new_count_q <= hunk_new_count_d;
		end
	end

	// a closed hunk carries an empty header
	a_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!hunk_open_q |-> (hunk_old_count_q == '0 && hunk_new_count_q == '0
			&& hunk_old_start_q == '0 && hunk_new_start_q == '0))
		else $error("closed hunk has nonzero header");

	// headers only leave an open hunk
	a_emit_open: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> hunk_open_q)
		else $error("emit without open hunk");

	// hunk never starts past the current old line
	a_start_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hunk_open_q |-> (hunk_old_start_q <= old_position_q))
		else $error("hunk start beyond old position");

	// end of script clears positions
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step && action == ACT_END) |=> (!hunk_open_q && old_position_q == '0
			&& new_position_q == '0))
		else $error("flush left state behind");

endmodule

// File: rtl/dhg_out_reg.sv
// Result register for hunk headers, driving the output channel.
// Depends on dhg_pkg and dhg_out_if.
module dhg_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  dhg_pkg::hunk_hdr_t hdr,
	output logic               free,
	dhg_out_if.source          hunk
);
	import dhg_pkg::*;

	logic      valid_q;
	hunk_hdr_t hdr_q;

	// slot can take a new header when empty or being drained this cycle
	assign free = !valid_q || hunk.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			hdr_q <= hdr;
		end
	end

	assign hunk.valid     = valid_q;
	assign hunk.old_start = hdr_q.old_start;
	assign hunk.old_count = hdr_q.old_count;
	assign hunk.new_start = hdr_q.new_start;
	assign hunk.new_count = hdr_q.new_count;

endmodule

// File: rtl/diff_hunk_grouper.sv
// Diff hunk grouper top level: input register, hunk state core, result register.
// Depends on dhg_pkg, dhg_in_if, dhg_out_if, dhg_cfg_if, dhg_core, dhg_out_reg.
//
// Takes one edit operation (equal, insert, delete) or an end-of-script marker
// per cycle and reports the header of each finished hunk: zero-based start and
// line count on the old and new side. A hunk opens at the first change with up
// to context_lines preceding lines and closes at the first equal line after its
// trailing context runs out; end of script flushes any open hunk and returns the
// line positions to zero. One transaction is accepted every cycle while the
// result register can drain; a closing transaction passes the input register
// and its header then the result register. Stalls on the output channel stall
// the input once the single result slot and the input register are both full.
// The user writes context_lines (reset 3) only while no transaction is in
// flight; the block does not enforce this. It applies from the next change on.
module diff_hunk_grouper (
	input  logic      clk,
	input  logic      arst_n,
	dhg_in_if.sink    item,
	dhg_out_if.source hunk,
	dhg_cfg_if.sink   cfg
);
	import dhg_pkg::*;

	ctx_t       context_lines_q;
	logic       item_valid_s1;
	logic       action_s1;
	logic [1:0] op_kind_s1;
	logic       out_free;
	logic       step;
	logic       emit;
	hunk_hdr_t  hdr;

	// context register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			context_lines_q <= CTX_RESET;
		end else if (cfg.valid) begin
			context_lines_q <= cfg.data;
		end
	end

	// input register
	assign step       = item_valid_s1 && out_free;
	assign item.ready = !item_valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item.ready) begin
			item_valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1  <= item.action;
			op_kind_s1 <= item.op_kind;
		end
	end

	dhg_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.action        (action_s1),
		.op_kind       (op_kind_s1),
		.context_lines (context_lines_q),
		.emit          (emit),
		.hdr           (hdr)
	);

	dhg_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && emit),
		.hdr    (hdr),
		.free   (out_free),
		.hunk   (hunk)
	);

endmodule

// File: sim/dhg_checker.sv
// Checker for the diff hunk grouper: watches the edit, config and header channels,
// predicts every hunk header and compares it field by field against the block.
// Depends on dhg_pkg and the dhg_in_if, dhg_out_if and dhg_cfg_if interfaces.
module dhg_checker (
	input  logic clk,
	input  logic arst_n,
	dhg_in_if    item,
	dhg_out_if   hunk,
	dhg_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import dhg_pkg::*;

	// predicted block state
	ctx_t       ctx_lines;
	ctx_t       ctx_left;
	logic       in_hunk;
	line_t      old_pos;
	line_t      new_pos;
	hunk_hdr_t  cur_hunk;

	hunk_hdr_t  hdr_q[$];
	int         errs = 0;

	// add with clamp at the line limit
	function automatic line_t line_add(input line_t v, input line_t by);
		logic [LINE_BITS:0] sum;
		sum = {1'b0, v} + {1'b0, by};
		return (sum > {1'b0, LINE_MAX}) ? LINE_MAX : sum[LINE_BITS-1:0];
	endfunction

	function automatic hunk_hdr_t empty_hunk();
		hunk_hdr_t h;
		h.old_start = '0;
		h.old_count = '0;
		h.new_start = '0;
		h.new_count = '0;
		return h;
	endfunction

	// append one predicted header at the tail of the queue
	function automatic void queue_hdr(input hunk_hdr_t h);
		hdr_q = {hdr_q, h};
	endfunction

	// advance the hunk state by one transaction, queue any header it closes
	task automatic apply_item(input logic act, input logic [1:0] op);
		line_t lead;
		if (act == ACT_END) begin
			if (in_hunk)
				queue_hdr(cur_hunk);
			in_hunk  = 1'b0;
			old_pos  = '0;
			new_pos  = '0;
			ctx_left = '0;
			cur_hunk = empty_hunk();
		end else begin
			case (op)
				OP_EQUAL: begin
					if (in_hunk) begin
						if (ctx_left != '0) begin
							cur_hunk.old_count = line_add(cur_hunk.old_count, line_t'(1));
							cur_hunk.new_count = line_add(cur_hunk.new_count, line_t'(1));
							ctx_left = ctx_left - ctx_t'(1);
						end else begin
							// trailing context used up: this line closes the hunk
							queue_hdr(cur_hunk);
							in_hunk  = 1'b0;
							cur_hunk = empty_hunk();
						end
					end
					old_pos = line_add(old_pos, line_t'(1));
					new_pos = line_add(new_pos, line_t'(1));
				end
				OP_INSERT, OP_DELETE: begin
					ctx_left = ctx_lines;
					if (!in_hunk) begin
						// leading context, limited by the start of the old file
						lead = (line_t'(ctx_lines) < old_pos) ? line_t'(ctx_lines) : old_pos;
						in_hunk = 1'b1;
						cur_hunk.old_count = lead;
						cur_hunk.new_count = lead;
						cur_hunk.old_start = old_pos - lead;
						cur_hunk.new_start = (lead > new_pos) ? '0 : new_pos - lead;
					end
					if (op == OP_INSERT) begin
						cur_hunk.new_count = line_add(cur_hunk.new_count, line_t'(1));
						new_pos = line_add(new_pos, line_t'(1));
					end else begin
						cur_hunk.old_count = line_add(cur_hunk.old_count, line_t'(1));
						old_pos = line_add(old_pos, line_t'(1));
					end
				end
				default: ; // unused kind: no effect
			endcase
		end
	endtask

	// compare one header transaction with the oldest prediction
	task automatic check_header();
		hunk_hdr_t want;
		if (hdr_q.size() == 0) begin
			$error("hunk header with none expected: %0d/%0d %0d/%0d",
				hunk.old_start, hunk.old_count, hunk.new_start, hunk.new_count);
			errs++;
		end else begin
			want = hdr_q.pop_front();
			if (hunk.old_start !== want.old_start) begin
				$error("old_start: expected %0d, got %0d", want.old_start, hunk.old_start);
				errs++;
			end
			if (hunk.old_count !== want.old_count) begin
				$error("old_count: expected %0d, got %0d", want.old_count, hunk.old_count);
				errs++;
			end
			if (hunk.new_start !== want.new_start) begin
				$error("new_start: expected %0d, got %0d", want.new_start, hunk.new_start);
				errs++;
			end
			if (hunk.new_count !== want.new_count) begin
				$error("new_count: expected %0d, got %0d", want.new_count, hunk.new_count);
				errs++;
			end
		end
	endtask

	// sample all channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_lines = CTX_RESET;
			ctx_left  = '0;
			in_hunk   = 1'b0;
			old_pos   = '0;
			new_pos   = '0;
			cur_hunk  = empty_hunk();
			hdr_q.delete();
		end else begin
			if (hunk.valid && hunk.ready)
				check_header();
			if (cfg.valid && cfg.ready)
				ctx_lines = cfg.data;
			if (item.valid && item.ready)
				apply_item(item.action, item.op_kind);
		end
		fail_count <= errs;
		pending    <= hdr_q.size();
	end

endmodule

// File: sim/testbench.sv
// Top-level testbench for diff_hunk_grouper: clock, reset, edit stimulus, config
// writes, header back-pressure and the verdict. Depends on dhg_pkg, the dhg_*_if
// interfaces, diff_hunk_grouper and dhg_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dhg_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE       = 4;      // wait after the headers drain, before a config write
	localparam int DRAIN        = 10;
	localparam int PHASE_ITEMS  = 150;
	localparam int PHASES       = 9;
	localparam int BURST_LEN    = 24;
	localparam int unsigned CYCLE_LIMIT = 200_000;

	logic clk;
	logic arst_n;

	dhg_in_if  item();
	dhg_out_if hunk();
	dhg_cfg_if cfg();

	int   fails;
	int   headers_due;
	ctx_t cur_ctx;
	bit   no_idle;
	int unsigned cycles = 0;

	diff_hunk_grouper i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.hunk   (hunk),
		.cfg    (cfg)
	);

	dhg_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.hunk       (hunk),
		.cfg        (cfg),
		.fail_count (fails),
		.pending    (headers_due)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// header sink: random stall before each transaction
	initial begin
		int stall;
		hunk.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				hunk.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			hunk.ready <= 1'b1;
			do @(posedge clk); while (!(hunk.valid && hunk.ready));
		end
	end

	// one edit transaction, with an optional random gap ahead of it
	task automatic send(input logic act, input logic [1:0] op, input bit fast);
		int gap;
		gap = (fast || no_idle) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid   <= 1'b1;
		item.action  <= act;
		item.op_kind <= op;
		do @(posedge clk); while (!item.ready);
	endtask

	task automatic edit(input logic [1:0] op);
		send(ACT_EDIT, op, 1'b0);
	endtask

	// drain all headers, let the pipeline settle, then write the context setting
	task automatic set_context(input ctx_t v);
		item.valid <= 1'b0;
		@(posedge clk);
		while (headers_due != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		cur_ctx = v;
	endtask

	// random edit script: runs of equal lines and change bursts, plus noise
	task automatic random_items(input int count);
		int         done;
		int         run_left;
		int         pick;
		bit         run_equal;
		logic [1:0] op;
		done      = 0;
		run_left  = 0;
		run_equal = 1'b1;
		while (done < count) begin
			if (run_left == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					send(ACT_END, 2'($urandom_range(0, 3)), 1'b0);
					done++;
				end else if (pick < 13) begin
					send(ACT_EDIT, OP_UNUSED, 1'b0);
				end else begin
					run_equal = (pick < 55);
					// equal runs straddle the trailing context length
					run_left = run_equal ? $urandom_range(1, int'(cur_ctx) + 2)
						: $urandom_range(1, 4);
				end
			end else begin
				if (run_equal)
					op = OP_EQUAL;
				else
					op = $urandom_range(0, 1) ? OP_INSERT : OP_DELETE;
				send(ACT_EDIT, op, 1'b0);
				run_left--;
				done++;
			end
		end
	endtask

	// main stimulus
	initial begin
		ctx_t v;
		clk          = 1'b0;
		arst_n       = 1'b0;
		item.valid   = 1'b0;
		item.action  = ACT_EDIT;
		item.op_kind = OP_EQUAL;
		cfg.valid    = 1'b0;
		cfg.data     = '0;
		cur_ctx      = CTX_RESET;
		no_idle      = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset context of three, leading context clipped at file start
		edit(OP_EQUAL);
		edit(OP_UNUSED);
		edit(OP_INSERT);
		edit(OP_DELETE);
		repeat (3) edit(OP_EQUAL);
		edit(OP_EQUAL);                  // closes the hunk
		edit(OP_DELETE);
		send(ACT_END, OP_UNUSED, 1'b0);  // flushes the open hunk
		send(ACT_END, OP_EQUAL, 1'b0);   // nothing open
		send(ACT_END, OP_DELETE, 1'b0);

		// zero context: old side runs ahead of the new side
		set_context(ctx_t'(0));
		repeat (3) edit(OP_DELETE);
		edit(OP_EQUAL);

		// wider context would reach below new-file line zero
		set_context(ctx_t'(3));
		edit(OP_INSERT);
		edit(OP_EQUAL);

		// context change while a hunk is open
		set_context(ctx_t'(0));
		repeat (3) edit(OP_EQUAL);
		edit(OP_DELETE);
		edit(OP_EQUAL);
		send(ACT_END, OP_INSERT, 1'b0);

		// random phases across context settings, extremes included
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: v = ctx_t'(0);
				1: v = ctx_t'(255);
				2: v = ctx_t'(1);
				3: v = ctx_t'(2);
				PHASES - 1: v = CTX_RESET;
				default: v = ($urandom_range(0, 3) == 0) ? ctx_t'($urandom_range(0, 255))
					: ctx_t'($urandom_range(0, 8));
			endcase
			set_context(v);
			no_idle = ($urandom_range(0, 3) == 0);
			random_items(PHASE_ITEMS);
		end

		// back-to-back run of deletes inside one hunk
		set_context(ctx_t'(2));
		no_idle = 1'b1;
		send(ACT_END, OP_EQUAL, 1'b0);
		repeat (5) edit(OP_EQUAL);
		for (int n = 0; n < BURST_LEN; n++)
			send(ACT_EDIT, OP_DELETE, 1'b1);
		repeat (3) edit(OP_EQUAL);
		edit(OP_INSERT);
		edit(OP_DELETE);
		edit(OP_EQUAL);
		send(ACT_END, OP_EQUAL, 1'b0);
		no_idle = 1'b0;

		// wait for every header, then a few more cycles
		item.valid <= 1'b0;
		@(posedge clk);
		while (headers_due != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
